### design/config_text_tokenizer_macros.svh
// Assertion macros shared by the checker of the configuration text tokenizer.
`ifndef CONFIG_TEXT_TOKENIZER_MACROS_SVH
`define CONFIG_TEXT_TOKENIZER_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define CTT_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define CTT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked across reset.
`define CTT_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/ctt_pkg.sv
// Types, codes and constants of the configuration text tokenizer.
package ctt_pkg;

  localparam int CTT_POS_WIDTH   = 16;
  localparam int CTT_QUEUE_DEPTH = 4;

  typedef logic [CTT_POS_WIDTH-1:0] pos_t;

  localparam pos_t CTT_POS_MAX = '1;
  localparam pos_t CTT_POS_ONE = pos_t'(1);

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_OPEN  = 8'h7B;
  localparam logic [7:0] CH_CLOSE = 8'h7D;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_END  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    KIND_BYTE     = 3'd0,
    KIND_WORD_END = 3'd1,
    KIND_OPEN     = 3'd2,
    KIND_CLOSE    = 3'd3,
    KIND_SEMI     = 3'd4,
    KIND_END      = 3'd5
  } token_kind_t;

  typedef enum logic [2:0] {
    MODE_BETWEEN = 3'b001,
    MODE_WORD    = 3'b010,
    MODE_COMMENT = 3'b100
  } scan_mode_t;

  typedef struct packed {
    op_t        operation;
    logic [7:0] text_byte;
  } in_item_t;

  typedef struct packed {
    token_kind_t token_kind;
    logic [7:0]  char_value;
    pos_t        token_line;
    pos_t        token_column;
    logic        last_of_run;
  } out_item_t;

  // One queue entry: the results caused by one input item.
  typedef struct packed {
    logic      two;
    out_item_t first;
    out_item_t second;
  } job_t;

endpackage

### design/ctt_front.sv
// Front part: takes text bytes, tracks mode and position, and forms result jobs.
module ctt_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ctt_pkg::in_item_t in_data,
  input  logic              queue_full,
  output logic              job_push,
  output ctt_pkg::job_t     job
);
  import ctt_pkg::*;

  scan_mode_t mode_r, mode_nxt;
  pos_t       line_r, line_nxt;
  pos_t       col_r, col_nxt;
  pos_t       wline_r, wline_nxt;
  pos_t       wcol_r, wcol_nxt;

  logic       accept;
  logic [7:0] c;
  logic       is_nl, is_space, is_punct, is_word_char;
  token_kind_t punct_kind;
  logic       has_we, has_x;
  out_item_t  extra, word_end;
  logic       bt_x, bt_start;
  scan_mode_t bt_mode;
  out_item_t  bt_item;
  pos_t       mv_line, mv_col;

  function automatic pos_t sat_inc(input pos_t v);
    return (v == CTT_POS_MAX) ? v : v + CTT_POS_ONE;
  endfunction

  assign accept   = in_valid && !queue_full;
  assign in_stall = queue_full;
  assign c        = in_data.text_byte;

  always_comb begin
    is_nl    = (c == CH_LF);
    is_space = (c == CH_SPACE) || (c == CH_TAB) || is_nl || (c == CH_CR);
    is_punct = 1'b1;
    punct_kind = KIND_OPEN;
    case (c)
      CH_OPEN:  punct_kind = KIND_OPEN;
      CH_CLOSE: punct_kind = KIND_CLOSE;
      CH_SEMI:  punct_kind = KIND_SEMI;
      default:  is_punct = 1'b0;
    endcase
    is_word_char = !is_punct && !is_space && (c != CH_HASH);
    mv_line = is_nl ? sat_inc(line_r) : line_r;
    mv_col  = is_nl ? CTT_POS_ONE : sat_inc(col_r);
  end

  // What a byte does when it arrives between tokens.
  always_comb begin
    bt_x     = 1'b0;
    bt_start = 1'b0;
    bt_mode  = MODE_BETWEEN;
    bt_item  = '{token_kind: KIND_BYTE, char_value: c, token_line: line_r,
                 token_column: col_r, last_of_run: 1'b0};
    if (c == CH_HASH) begin
      bt_mode = MODE_COMMENT;
    end else if (is_space) begin
      bt_mode = MODE_BETWEEN;
    end else if (is_punct) begin
      bt_x = 1'b1;
      bt_item.token_kind = punct_kind;
    end else begin
      bt_x     = 1'b1;
      bt_start = 1'b1;
      bt_mode  = MODE_WORD;
    end
  end

  always_comb begin
    mode_nxt  = mode_r;
    line_nxt  = line_r;
    col_nxt   = col_r;
    wline_nxt = wline_r;
    wcol_nxt  = wcol_r;
    has_we    = 1'b0;
    has_x     = 1'b0;
    extra     = bt_item;
    word_end  = '{token_kind: KIND_WORD_END, char_value: 8'h00, token_line: wline_r,
                  token_column: wcol_r, last_of_run: 1'b0};
    if (in_data.operation == OP_END) begin
      has_we    = (mode_r == MODE_WORD);
      has_x     = 1'b1;
      extra     = '{token_kind: KIND_END, char_value: 8'h00, token_line: line_r,
                    token_column: col_r, last_of_run: 1'b0};
      mode_nxt  = MODE_BETWEEN;
      line_nxt  = CTT_POS_ONE;
      col_nxt   = CTT_POS_ONE;
      wline_nxt = CTT_POS_ONE;
      wcol_nxt  = CTT_POS_ONE;
    end else begin
      line_nxt = mv_line;
      col_nxt  = mv_col;
      unique case (mode_r)
        MODE_COMMENT: begin
          if (is_nl) begin
            mode_nxt = MODE_BETWEEN;
          end
        end
        MODE_WORD: begin
          if (is_word_char) begin
            has_x = 1'b1;
            extra = '{token_kind: KIND_BYTE, char_value: c, token_line: wline_r,
                      token_column: wcol_r, last_of_run: 1'b0};
          end else begin
            has_we   = 1'b1;
            has_x    = bt_x;
            mode_nxt = bt_mode;
          end
        end
        MODE_BETWEEN: begin
          has_x    = bt_x;
          mode_nxt = bt_mode;
          if (bt_start) begin
            wline_nxt = line_r;
            wcol_nxt  = col_r;
          end
        end
        default: mode_nxt = MODE_BETWEEN;
      endcase
    end
  end

  // A pending word end always goes first; the other result follows it.
  always_comb begin
    job.two    = has_we && has_x;
    job.first  = has_we ? word_end : extra;
    job.second = extra;
    job.first.last_of_run  = !(has_we && has_x);
    job.second.last_of_run = 1'b1;
    job_push = accept && (has_we || has_x);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_BETWEEN;
      line_r  <= CTT_POS_ONE;
      col_r   <= CTT_POS_ONE;
      wline_r <= CTT_POS_ONE;
      wcol_r  <= CTT_POS_ONE;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      line_r  <= line_nxt;
      col_r   <= col_nxt;
      wline_r <= wline_nxt;
      wcol_r  <= wcol_nxt;
    end
  end

endmodule

### design/ctt_queue.sv
// Short job queue that decouples the front part from the result stage.
module ctt_queue #(
  parameter int DEPTH = ctt_pkg::CTT_QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ctt_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output ctt_pkg::job_t head_job
);
  import ctt_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  job_t             store_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full       = (count_r == CNT_FULL);
  assign head_valid = (count_r != '0);
  assign head_job   = store_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

### design/ctt_back.sv
// Back part: unpacks each job into one or two results on the output register.
module ctt_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  ctt_pkg::job_t      head_job,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output ctt_pkg::out_item_t out_data
);
  import ctt_pkg::*;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;
  logic      phase_r, phase_nxt;
  logic      load;

  // The output register takes a new result when it is empty or being drained.
  assign load      = head_valid && (!out_valid_r || !out_stall);
  assign pop       = load && (phase_r || !head_job.two);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    phase_nxt     = phase_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      phase_nxt     = !pop;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= phase_r ? head_job.second : head_job.first;
    end
  end

endmodule

### design/config_text_tokenizer.sv
// Top level of the configuration text tokenizer.
// Streams a configuration text one byte per transaction and turns it into word bytes, word
// ends, brace and semicolon tokens and an end token, each tagged with its line and column.
// One input transaction is taken every cycle unless the job queue is full. The first result
// of an input passes through the job queue and then into the output register. An input that
// closes a word with a brace, a semicolon or the end of text gives two results, which leave in
// turn; a queue of QUEUE_DEPTH jobs between the front and the output stage absorbs such bursts,
// and the input stalls only while that queue is full. There is no start-up sweep after reset.
module config_text_tokenizer #(
  parameter int QUEUE_DEPTH = ctt_pkg::CTT_QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ctt_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ctt_pkg::out_item_t out_data
);
  import ctt_pkg::*;

  job_t front_job, head_job;
  logic job_push, queue_full, head_valid, head_pop;

  ctt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .queue_full (queue_full),
    .job_push   (job_push),
    .job        (front_job)
  );

  ctt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (job_push),
    .push_job   (front_job),
    .full       (queue_full),
    .pop        (head_pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  ctt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (head_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

### design/ctt_checker.sv
// Port-level checks of the configuration text tokenizer and their binding.
`include "config_text_tokenizer_macros.svh"

module ctt_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input ctt_pkg::out_item_t out_data
);
  import ctt_pkg::*;

  logic end_shown, marker_shown, pos_ok;

  assign end_shown    = out_valid && (out_data.token_kind == KIND_END);
  assign marker_shown = out_valid && ((out_data.token_kind == KIND_END) ||
                                      (out_data.token_kind == KIND_WORD_END));
  assign pos_ok       = (out_data.token_line != '0) && (out_data.token_column != '0);

  `CTT_ASSERT_NEXT(a_out_held, out_valid && out_stall, out_valid, "result dropped while stalled")
  `CTT_ASSERT_NEXT_ALWAYS(a_reset_empty, !rst_n, !out_valid, "result shown after reset")
  `CTT_ASSERT_IMPLY(a_end_last, end_shown, out_data.last_of_run, "end token not last of run")
  `CTT_ASSERT_IMPLY(a_pos_nonzero, out_valid, pos_ok, "token position is zero")
  `CTT_ASSERT_IMPLY(a_end_char, marker_shown, out_data.char_value == 8'h00, "marker has a char")

endmodule

bind config_text_tokenizer ctt_checker u_ctt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

### dv/tb_top.sv
// Self-checking testbench for the configuration text tokenizer.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ctt_pkg::*;

  localparam int RESET_CYCLES   = 10;
  localparam int SETTLE_CYCLES  = 16;
  localparam int MAX_IDLE       = 8;
  localparam int HOLD_CYCLES    = 150;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 1100;
  localparam int MODE_CHUNK     = 150;
  localparam int MAX_REPORTS    = 30;
  localparam int LONG_RUN       = 100;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  config_text_tokenizer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Tokenizer state as the testbench expects it to be.
  scan_mode_t scan_state = MODE_BETWEEN;
  pos_t       line_pos   = CTT_POS_ONE;
  pos_t       col_pos    = CTT_POS_ONE;
  pos_t       word_line  = CTT_POS_ONE;
  pos_t       word_col   = CTT_POS_ONE;

  out_item_t  pending_tokens [$];

  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  int rx_hold_request = 0;

  int items_sent = 0;
  int end_marks = 0;
  int tokens_checked = 0;
  int input_stall_cycles = 0;
  int fail_count = 0;
  int idle_cycles = 0;
  int kind_tally [6];

  function automatic bit is_blank(logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
  endfunction

  function automatic bit breaks_word(logic [7:0] c);
    return is_blank(c) || (c == CH_OPEN) || (c == CH_CLOSE) || (c == CH_SEMI) ||
           (c == CH_HASH);
  endfunction

  function automatic pos_t bump(pos_t v);
    return (v == CTT_POS_MAX) ? v : v + CTT_POS_ONE;
  endfunction

  function automatic void advance(logic [7:0] c);
    if (c == CH_LF) begin
      line_pos = bump(line_pos);
      col_pos  = CTT_POS_ONE;
    end else begin
      col_pos = bump(col_pos);
    end
  endfunction

  function automatic out_item_t make_token(token_kind_t kind, logic [7:0] ch, pos_t ln,
                                           pos_t col);
    out_item_t t;
    t.token_kind   = kind;
    t.char_value   = ch;
    t.token_line   = ln;
    t.token_column = col;
    t.last_of_run  = 1'b0;
    return t;
  endfunction

  // Works out the tokens that one accepted transaction produces and queues them.
  function automatic void tokenize_item(in_item_t it);
    out_item_t   res [2];
    int          n;
    logic [7:0]  c;
    token_kind_t pk;
    bit          is_punct;
    n = 0;
    c = it.text_byte;
    is_punct = 1'b1;
    pk = KIND_BYTE;
    case (c)
      CH_OPEN:  pk = KIND_OPEN;
      CH_CLOSE: pk = KIND_CLOSE;
      CH_SEMI:  pk = KIND_SEMI;
      default:  is_punct = 1'b0;
    endcase
    if (it.operation == OP_END) begin
      if (scan_state == MODE_WORD) begin
        res[n] = make_token(KIND_WORD_END, 8'h00, word_line, word_col);
        n++;
      end
      res[n] = make_token(KIND_END, 8'h00, line_pos, col_pos);
      n++;
      scan_state = MODE_BETWEEN;
      line_pos   = CTT_POS_ONE;
      col_pos    = CTT_POS_ONE;
      word_line  = CTT_POS_ONE;
      word_col   = CTT_POS_ONE;
    end else if (scan_state == MODE_COMMENT) begin
      if (c == CH_LF) scan_state = MODE_BETWEEN;
      advance(c);
    end else if (scan_state == MODE_WORD && !breaks_word(c)) begin
      res[n] = make_token(KIND_BYTE, c, word_line, word_col);
      n++;
      advance(c);
    end else begin
      // A delimiter closes the open word first and is then handled as between tokens.
      if (scan_state == MODE_WORD) begin
        res[n] = make_token(KIND_WORD_END, 8'h00, word_line, word_col);
        n++;
        scan_state = MODE_BETWEEN;
      end
      if (c == CH_HASH) begin
        scan_state = MODE_COMMENT;
      end else if (is_punct) begin
        res[n] = make_token(pk, c, line_pos, col_pos);
        n++;
      end else if (!is_blank(c)) begin
        word_line  = line_pos;
        word_col   = col_pos;
        scan_state = MODE_WORD;
        res[n] = make_token(KIND_BYTE, c, word_line, word_col);
        n++;
      end
      advance(c);
    end
    for (int i = 0; i < n; i++) begin
      res[i].last_of_run = (i == n - 1);
      pending_tokens.insert(pending_tokens.size(), res[i]);
    end
  endfunction

  task automatic flag_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("%0t: %s expected %0h, got %0h", $realtime, name, exp_v, got_v);
  endtask

  // Predicts on every accepted input transaction and checks every accepted result.
  always @(posedge clk) begin : scoreboard
    out_item_t want;
    bit        moved;
    moved = 1'b0;
    if (rst_n) begin
      if (in_valid && in_stall === 1'b0) begin
        tokenize_item(in_data);
        moved = 1'b1;
      end else if (in_valid && in_stall === 1'b1) begin
        input_stall_cycles++;
      end
      if (out_valid === 1'b1 && !out_stall) begin
        moved = 1'b1;
        tokens_checked++;
        if (out_data.token_kind <= KIND_END) kind_tally[out_data.token_kind]++;
        if (pending_tokens.size() == 0) begin
          flag_field("unexpected token (none expected), kind", 16'hxxxx,
                     16'(out_data.token_kind));
        end else begin
          want = pending_tokens.pop_front();
          if (out_data.token_kind !== want.token_kind)
            flag_field("token_kind", 16'(want.token_kind), 16'(out_data.token_kind));
          if (out_data.char_value !== want.char_value)
            flag_field("char_value", 16'(want.char_value), 16'(out_data.char_value));
          if (out_data.token_line !== want.token_line)
            flag_field("token_line", 16'(want.token_line), 16'(out_data.token_line));
          if (out_data.token_column !== want.token_column)
            flag_field("token_column", 16'(want.token_column), 16'(out_data.token_column));
          if (out_data.last_of_run !== want.last_of_run)
            flag_field("last_of_run", 16'(want.last_of_run), 16'(out_data.last_of_run));
        end
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d tokens still due", $realtime,
               WATCHDOG_LIMIT, pending_tokens.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side: stalls a random number of cycles before each transaction, or holds off
  // for a long stretch when a test asks for it.
  initial begin : token_sink
    int pause;
    forever begin
      if (rx_hold_request > 0) begin
        pause = rx_hold_request;
        rx_hold_request = 0;
      end else begin
        pause = rx_quiet ? 0 : $urandom_range(0, MAX_IDLE);
      end
      if (pause > 0) begin
        out_stall <= 1'b1;
        repeat (pause) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // Offers one transaction and returns at the edge where it is taken. Valid stays high
  // afterwards so that a following transaction with no gap goes out back to back.
  task automatic send_item(op_t op, logic [7:0] b);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{operation: op, text_byte: b};
    do @(posedge clk); while (in_stall !== 1'b0);
    items_sent++;
    if (op == OP_END) end_marks++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(OP_BYTE, s[i]);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_tokens.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] word_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (breaks_word(c));
    return c;
  endfunction

  task automatic test_punctuation();
    send_item(OP_BYTE, CH_OPEN);
    send_item(OP_BYTE, CH_SPACE);
    send_item(OP_BYTE, CH_CLOSE);
    send_item(OP_BYTE, CH_SEMI);
  endtask

  // Words of extreme byte values, each closed by a different delimiter.
  task automatic test_word_delimiters();
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_BYTE, CH_SEMI);
    send_item(OP_BYTE, 8'h80);
    send_item(OP_BYTE, CH_OPEN);
    send_text("a}b");
    send_item(OP_BYTE, CH_TAB);
    send_item(OP_BYTE, 8'h7F);
    send_item(OP_BYTE, CH_CR);
    send_item(OP_BYTE, 8'h01);
    send_item(OP_BYTE, CH_LF);
    send_text("e#");
    send_item(OP_BYTE, CH_LF);
  endtask

  task automatic test_comment();
    send_text("#;{");
    send_item(OP_BYTE, CH_LF);
    send_text("#x");
    send_item(OP_END, 8'h00);
  endtask

  task automatic test_end_of_text();
    send_item(OP_BYTE, "w");
    send_item(OP_END, 8'hFF);
    send_item(OP_END, 8'h5A);
  endtask

  // A long line and a long run of empty lines carry the position counters far from 1.
  task automatic test_long_runs();
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    repeat (LONG_RUN) send_item(OP_BYTE, CH_SPACE);
    send_text("kv;");
    repeat (LONG_RUN) send_item(OP_BYTE, CH_LF);
    send_text("{x");
    send_item(OP_END, 8'h00);
    wait_drained();
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  // The sink holds off while words closed by semicolons stream in back to back, so the
  // internal queue fills and the input must stall.
  task automatic test_backpressure();
    tx_quiet = 1'b1;
    rx_hold_request = HOLD_CYCLES;
    repeat (30) begin
      send_item(OP_BYTE, word_char());
      send_item(OP_BYTE, CH_SEMI);
    end
    tx_quiet = 1'b0;
    wait_drained();
  endtask

  // Mostly well-formed configuration text with random content, plus stray bytes and
  // early ends of text. The idling pattern changes every MODE_CHUNK (150) transactions.
  task automatic test_random_text(int n_items);
    int target;
    int next_switch;
    int r;
    int len;
    int mode;
    logic [7:0] c;
    target = items_sent + n_items;
    next_switch = items_sent;
    while (items_sent < target) begin
      if (items_sent >= next_switch) begin
        mode = $urandom_range(0, 3);
        tx_quiet = mode[0];
        rx_quiet = mode[1];
        next_switch += MODE_CHUNK;
      end
      r = $urandom_range(0, 99);
      if (r < 35) begin
        len = $urandom_range(1, 6);
        repeat (len) send_item(OP_BYTE, word_char());
      end else if (r < 55) begin
        case ($urandom_range(0, 2))
          0:       send_item(OP_BYTE, CH_OPEN);
          1:       send_item(OP_BYTE, CH_CLOSE);
          default: send_item(OP_BYTE, CH_SEMI);
        endcase
      end else if (r < 72) begin
        case ($urandom_range(0, 3))
          0:       send_item(OP_BYTE, CH_SPACE);
          1:       send_item(OP_BYTE, CH_TAB);
          2:       send_item(OP_BYTE, CH_CR);
          default: send_item(OP_BYTE, CH_LF);
        endcase
      end else if (r < 84) begin
        send_item(OP_BYTE, CH_HASH);
        len = $urandom_range(0, 5);
        repeat (len) begin
          do c = 8'($urandom_range(0, 255)); while (c == CH_LF);
          send_item(OP_BYTE, c);
        end
        if ($urandom_range(0, 4) == 0) send_item(OP_END, 8'($urandom_range(0, 255)));
        else send_item(OP_BYTE, CH_LF);
      end else if (r < 95) begin
        send_item(OP_BYTE, 8'($urandom_range(0, 255)));
      end else begin
        send_item(OP_END, 8'($urandom_range(0, 255)));
      end
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  initial begin : run_tests
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_punctuation();
    test_word_delimiters();
    test_comment();
    test_end_of_text();
    test_backpressure();
    test_long_runs();
    test_random_text(RANDOM_ITEMS);
    wait_drained();
    $display("Covered %0d input transactions (%0d end of text) and %0d tokens;",
             items_sent, end_marks, tokens_checked);
    $display("kinds byte/end-of-word/open/close/semi/end: %0d/%0d/%0d/%0d/%0d/%0d, %0d %s",
             kind_tally[0], kind_tally[1], kind_tally[2], kind_tally[3], kind_tally[4],
             kind_tally[5], input_stall_cycles, "cycles of input stall");
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
